// ===== rtl/core/sfr_pkg.sv =====
// Shared types, status codes and check functions for the serial frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // End-of-frame status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ADDR    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PAYLOAD_CRC = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HEADER_CRC  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 3'd4;

    localparam logic [15:0] XMODEM_POLY = 16'h1021;

    typedef struct packed {
        logic [BYTE_W-1:0] own_addr;
        logic [BYTE_W-1:0] bcast_addr;
        logic [BYTE_W-1:0] start_sym;
        logic [BYTE_W-1:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic                has;
        logic                kind;
        logic [BYTE_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   frame_length;
        logic [BYTE_W-1:0]   source;
        logic [BYTE_W-1:0]   destination;
    } t_result;

    // Bytewise CRC-7 update of the header check
    function automatic logic [7:0] hcrc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] d;
        d = b ^ {crc[6:0], 1'b0};
        if (d[7]) begin
            d = d ^ 8'h09;
        end
        return d ^ (crc & 8'h78) ^ {crc[3:0], 4'b0000} ^ {4'b0000, crc[6:3]};
    endfunction

    // Final fold of the header check, low bit forced high
    function automatic logic [7:0] hcrc_final(input logic [7:0] crc);
        logic [7:0] f;
        f = {crc[6:0], 1'b0} ^ {crc[3:0], 4'b0000} ^ (crc & 8'h70) ^ {4'b0000, crc[6:3]};
        return f | 8'h01;
    endfunction

    // CRC-16 XMODEM, one byte
    function automatic logic [15:0] xmodem_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ XMODEM_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/serial_frame_receiver.sv =====
// Top level of the serial frame receiver: input register, frame logic, result register.
`timescale 1ns / 1ps

// The receiver takes one received byte per beat on the input channel and
// delivers at most one result beat per byte: a payload byte (kind 0) or an
// end-of-frame status (kind 1: ok, not addressed, payload CRC error, header
// CRC error, too long). Every beat carries the length, source and destination
// of the current header. A byte is taken every clock cycle when the output
// side keeps up; a byte lands in the input register, is worked through the
// frame state machine and CRC logic, and its result is then loaded into the
// result register. The single input register and single result register
// set the throughput of one byte per cycle; a stalled output holds both
// stages and back-pressures the input. Configuration registers (own address,
// broadcast address, start symbol, maximum length) are written through the
// configuration channel, which is always ready; write them only while no
// frame is in flight.

module serial_frame_receiver
    import sfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [BYTE_W-1:0]    o_data,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BYTE_W-1:0]    o_frame_length,
    output logic [BYTE_W-1:0]    o_source,
    output logic [BYTE_W-1:0]    o_destination,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SYM  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd3;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           step_result;
    logic              step;

    // Advance the byte in the input register when the result slot is free
    // or is being emptied in this cycle.
    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_addr   <= 8'd0;
            r_cfg.bcast_addr <= 8'd255;
            r_cfg.start_sym  <= 8'd1;
            r_cfg.max_len    <= 8'd255;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OWN_ADDR:   r_cfg.own_addr   <= i_cfg_data;
                CFG_BCAST_ADDR: r_cfg.bcast_addr <= i_cfg_data;
                CFG_START_SYM:  r_cfg.start_sym  <= i_cfg_data;
                CFG_MAX_LEN:    r_cfg.max_len    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfr_frame_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // Result register: load on a producing step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= step_result.has;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && step_result.has) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_data         = r_out.data;
    assign o_status       = r_out.status;
    assign o_frame_length = r_out.frame_length;
    assign o_source       = r_out.source;
    assign o_destination  = r_out.destination;

endmodule

// ===== rtl/core/sfr_frame_fsm.sv =====
// Frame state machine: hunts, checks the header, tracks payload and CRC bytes.
`timescale 1ns / 1ps

module sfr_frame_fsm
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_CRC_LO  = 3'd3;
    localparam logic [2:0] PH_CRC_HI  = 3'd4;

    logic [2:0]        r_phase,   n_phase;
    logic [1:0]        r_hdr_idx, n_hdr_idx;
    logic [BYTE_W-1:0] r_len,     n_len;
    logic [BYTE_W-1:0] r_dst,     n_dst;
    logic [BYTE_W-1:0] r_src,     n_src;
    logic [7:0]        r_hcrc,    n_hcrc;
    logic [15:0]       r_pcrc,    n_pcrc;
    logic [BYTE_W-1:0] r_count,   n_count;
    logic [BYTE_W-1:0] r_crc_lo,  n_crc_lo;
    logic              r_too_long, n_too_long;

    logic [BYTE_W-1:0] count_inc;
    logic [15:0]       crc_got;

    assign count_inc = r_count + 8'd1;
    assign crc_got   = {i_byte, r_crc_lo};

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_len      = r_len;
        n_dst      = r_dst;
        n_src      = r_src;
        n_hcrc     = r_hcrc;
        n_pcrc     = r_pcrc;
        n_count    = r_count;
        n_crc_lo   = r_crc_lo;
        n_too_long = r_too_long;

        o_result              = '0;
        o_result.frame_length = r_len;
        o_result.source       = r_src;
        o_result.destination  = r_dst;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_hdr_idx != 2'd3) begin
                    n_hcrc    = hcrc_step(r_hcrc, i_byte);
                    n_hdr_idx = r_hdr_idx + 2'd1;
                    if (r_hdr_idx == 2'd0) begin
                        n_len = i_byte;
                    end else if (r_hdr_idx == 2'd1) begin
                        n_dst = i_byte;
                    end else begin
                        n_src = i_byte;
                    end
                end else begin
                    n_hdr_idx = 2'd0;
                    if (i_byte != hcrc_final(r_hcrc)) begin
                        // drop the frame and hunt again
                        n_phase         = PH_HUNT;
                        o_result.has    = 1'b1;
                        o_result.kind   = 1'b1;
                        o_result.status = ST_HEADER_CRC;
                    end else begin
                        n_too_long = r_len > i_cfg.max_len;
                        n_pcrc     = '0;
                        n_count    = '0;
                        n_phase    = (r_len == '0) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_pcrc  = xmodem_step(r_pcrc, i_byte);
                n_count = count_inc;
                if (count_inc == r_len) begin
                    n_phase = PH_CRC_LO;
                end
                o_result.has  = !r_too_long;
                o_result.data = i_byte;
            end
            PH_CRC_LO: begin
                n_crc_lo = i_byte;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_phase       = PH_HUNT;
                n_too_long    = 1'b0;
                o_result.has  = 1'b1;
                o_result.kind = 1'b1;
                if (r_too_long) begin
                    o_result.status = ST_TOO_LONG;
                end else if (crc_got != r_pcrc) begin
                    o_result.status = ST_PAYLOAD_CRC;
                end else if (r_dst == i_cfg.own_addr || r_dst == i_cfg.bcast_addr) begin
                    o_result.status = ST_OK;
                end else begin
                    o_result.status = ST_NOT_ADDR;
                end
            end
            default: begin
                // hunting, and any unused code
                n_phase = PH_HUNT;
                if (i_byte == i_cfg.start_sym) begin
                    n_phase   = PH_HEADER;
                    n_hdr_idx = 2'd0;
                    n_hcrc    = '0;
                end
            end
        endcase

        if (!i_step) begin
            o_result.has = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_hdr_idx  <= '0;
            r_len      <= '0;
            r_dst      <= '0;
            r_src      <= '0;
            r_hcrc     <= '0;
            r_pcrc     <= '0;
            r_count    <= '0;
            r_crc_lo   <= '0;
            r_too_long <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_len      <= n_len;
            r_dst      <= n_dst;
            r_src      <= n_src;
            r_hcrc     <= n_hcrc;
            r_pcrc     <= n_pcrc;
            r_count    <= n_count;
            r_crc_lo   <= n_crc_lo;
            r_too_long <= n_too_long;
        end
    end

endmodule
